/* hdl/tomi_pkg.sv */
package tomi_pkg;

    // Default datapath sizes (Q16.16 coordinates)
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Register field widths
    localparam int PERIOD_W = 31;
    localparam int INV_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // One lane per axis
    localparam int NUM_LANES = 3;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 31'd65536;
    localparam logic [INV_W-1:0]    INV_RST     = 32'hFFFF_FFFF;
    localparam logic                SOLVENT_RST = 1'b1;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_X     = 3'd0,
        CFG_PERIOD_Y     = 3'd1,
        CFG_PERIOD_Z     = 3'd2,
        CFG_INV_PERIOD_X = 3'd3,
        CFG_INV_PERIOD_Y = 3'd4,
        CFG_INV_PERIOD_Z = 3'd5,
        CFG_SOLVENT      = 3'd6
    } cfg_reg_t;

endpackage

/* hdl/truncated_octahedron_min_image.sv */
// Channel   Signals                                    Handshake
// --------  -----------------------------------------  ---------------------------------
// input     start, busy, disp_x, disp_y, disp_z        start & !busy accepts a vector
// result    done, image_x, image_y, image_z            done marks one cycle, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready writes
//
// Nine-stage pipeline: an accepted vector passes through every stage register in
// turn before it shows on the result ports, and a new vector may enter in every
// cycle. The depth is set by the split fraction multiply, the fold and wrap steps,
// the scale-back multiply and the round/saturate/negate tail. busy stays low;
// cfg_ready is always high. rst_n clears the valid chain and loads the register
// defaults.
module truncated_octahedron_min_image #(
    parameter int COORD_WIDTH = tomi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tomi_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       disp_x,
    input  logic signed [COORD_WIDTH-1:0]       disp_y,
    input  logic signed [COORD_WIDTH-1:0]       disp_z,
    output logic                                done,
    output logic signed [COORD_WIDTH-1:0]       image_x,
    output logic signed [COORD_WIDTH-1:0]       image_y,
    output logic signed [COORD_WIDTH-1:0]       image_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tomi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tomi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NL    = tomi_pkg::NUM_LANES;
    localparam int CW    = COORD_WIDTH;
    localparam int IW    = tomi_pkg::INV_W;
    localparam int PW    = tomi_pkg::PERIOD_W;
    localparam int FW    = FRAC_BITS + IW;
    localparam int HI_W  = CW / 2;
    localparam int LO_W  = CW - HI_W;
    localparam int MW    = CW + IW;
    localparam int SUMW  = (FW > MW) ? FW : MW;
    localparam int PRODW = IW + PW;
    localparam int RW    = PRODW - IW;
    localparam int SATW  = (CW > RW) ? CW : RW;
    localparam int LAT   = 9;

    localparam logic [FW-1:0]   FHALF   = FW'(1) << (FW - 1);
    localparam logic [FW+1:0]   WRAP_TH = (FW + 2)'(3) << (FW - 2);
    localparam logic [PRODW-1:0] RND    = PRODW'(1) << (IW - 1);
    localparam logic [SATW-1:0] LIM     = SATW'(1) << (CW - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PW-1:0] period_reg [NL];
    logic [IW-1:0] inv_reg    [NL];
    logic          solvent_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Write one register per transaction; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++)
            begin
                period_reg[i] <= tomi_pkg::PERIOD_RST;
                inv_reg[i]    <= tomi_pkg::INV_RST;
            end
            solvent_reg <= tomi_pkg::SOLVENT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tomi_pkg::cfg_reg_t'(cfg_index))
                tomi_pkg::CFG_PERIOD_X:     period_reg[0] <= cfg_data[PW-1:0];
                tomi_pkg::CFG_PERIOD_Y:     period_reg[1] <= cfg_data[PW-1:0];
                tomi_pkg::CFG_PERIOD_Z:     period_reg[2] <= cfg_data[PW-1:0];
                tomi_pkg::CFG_INV_PERIOD_X: inv_reg[0]    <= cfg_data[IW-1:0];
                tomi_pkg::CFG_INV_PERIOD_Y: inv_reg[1]    <= cfg_data[IW-1:0];
                tomi_pkg::CFG_INV_PERIOD_Z: inv_reg[2]    <= cfg_data[IW-1:0];
                tomi_pkg::CFG_SOLVENT:      solvent_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic [LAT:1]  vld_reg;
    logic [LAT:1]  vld_next;
    logic [LAT-1:1] byp_reg;
    logic [LAT-1:1] byp_next;
    logic [CW-1:0] dly_reg  [1:LAT-1][NL];
    logic [CW-1:0] dly_next [1:LAT-1][NL];

    logic [CW-1:0] disp_lane [NL];

    logic [CW-1:0]      mag1_reg [NL], mag1_next [NL];
    logic               n1_reg   [NL], n1_next   [NL];
    logic [HI_W+IW-1:0] phi2_reg [NL], phi2_next [NL];
    logic [LO_W+IW-1:0] plo2_reg [NL], plo2_next [NL];
    logic               n2_reg   [NL], n2_next   [NL];
    logic [FW-1:0]      m3_reg   [NL], m3_next   [NL];
    logic               n3_reg   [NL], n3_next   [NL];
    logic [FW-1:0]      m4_reg   [NL], m4_next   [NL];
    logic               n4_reg   [NL], n4_next   [NL];
    logic [FW-1:0]      m5_reg   [NL], m5_next   [NL];
    logic               n5_reg   [NL], n5_next   [NL];
    logic               flip5_reg, flip5_next;
    logic [IW-1:0]      m6_reg   [NL], m6_next   [NL];
    logic               n6_reg   [NL], n6_next   [NL];
    logic [PRODW-1:0]   p7_reg   [NL], p7_next   [NL];
    logic               n7_reg   [NL], n7_next   [NL];
    logic [CW-1:0]      r8_reg   [NL], r8_next   [NL];
    logic               n8_reg   [NL], n8_next   [NL];
    logic [CW-1:0]      img_reg  [NL], img_next  [NL];

    logic [SUMW-1:0]  sum3  [NL];
    logic [FW-1:0]    fix6  [NL];
    logic [FW+1:0]    total5;
    logic [PRODW-1:0] rnd8  [NL];
    logic [SATW-1:0]  r8ext [NL];

    assign disp_lane[0] = disp_x;
    assign disp_lane[1] = disp_y;
    assign disp_lane[2] = disp_z;

    // Advance valid and bypass flags with the data
    always_comb
    begin
        vld_next[1] = start && !busy;
        byp_next[1] = !solvent_reg;
        for (int s = 2; s <= LAT; s++)
        begin
            vld_next[s] = vld_reg[s-1];
        end
        for (int s = 2; s <= LAT - 1; s++)
        begin
            byp_next[s] = byp_reg[s-1];
        end
        for (int i = 0; i < NL; i++)
        begin
            dly_next[1][i] = disp_lane[i];
            for (int s = 2; s <= LAT - 1; s++)
            begin
                dly_next[s][i] = dly_reg[s-1][i];
            end
        end
    end

    // Per-lane arithmetic, one stage per group
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            // Stage 1: sign and magnitude
            n1_next[i]   = disp_lane[i][CW-1];
            mag1_next[i] = disp_lane[i][CW-1] ? (~disp_lane[i] + CW'(1)) : disp_lane[i];

            // Stage 2: split fraction multiply
            phi2_next[i] = (HI_W+IW)'(mag1_reg[i][CW-1:LO_W]) * (HI_W+IW)'(inv_reg[i]);
            plo2_next[i] = (LO_W+IW)'(mag1_reg[i][LO_W-1:0]) * (LO_W+IW)'(inv_reg[i]);
            n2_next[i]   = n1_reg[i];

            // Stage 3: merge partial products, keep the fraction bits
            sum3[i]    = (SUMW'(phi2_reg[i]) << LO_W) + SUMW'(plo2_reg[i]);
            m3_next[i] = sum3[i][FW-1:0];
            n3_next[i] = n2_reg[i];

            // Stage 4: fold into [-0.5, 0.5], zero counts as positive
            if (m3_reg[i][FW-1])
            begin
                m4_next[i] = ~m3_reg[i] + FW'(1);
                n4_next[i] = !n3_reg[i];
            end
            else
            begin
                m4_next[i] = m3_reg[i];
                n4_next[i] = n3_reg[i] && (m3_reg[i] != '0);
            end

            // Stage 5: hold lanes while the wrap test is formed
            m5_next[i] = m4_reg[i];
            n5_next[i] = n4_reg[i];

            // Stage 6: pull toward the octahedral face, truncate to Q0.32
            if (flip5_reg)
            begin
                fix6[i]    = FHALF - m5_reg[i];
                n6_next[i] = !n5_reg[i] && (fix6[i] != '0);
            end
            else
            begin
                fix6[i]    = m5_reg[i];
                n6_next[i] = n5_reg[i];
            end
            m6_next[i] = fix6[i][FW-1:FRAC_BITS];

            // Stage 7: scale back by the period
            p7_next[i] = PRODW'(m6_reg[i]) * PRODW'(period_reg[i]);
            n7_next[i] = n6_reg[i];

            // Stage 8: round half away from zero, clamp to the signed range
            rnd8[i]  = p7_reg[i] + RND;
            r8ext[i] = SATW'(rnd8[i][PRODW-1:IW]);
            if (n7_reg[i])
            begin
                r8_next[i] = (r8ext[i] > LIM) ? LIM[CW-1:0] : r8ext[i][CW-1:0];
            end
            else
            begin
                r8_next[i] = (r8ext[i] > LIM - SATW'(1)) ? (LIM[CW-1:0] - CW'(1))
                                                         : r8ext[i][CW-1:0];
            end
            n8_next[i] = n7_reg[i];

            // Stage 9: apply sign or pass the vector through
            if (byp_reg[LAT-1])
            begin
                img_next[i] = dly_reg[LAT-1][i];
            end
            else
            begin
                img_next[i] = n8_reg[i] ? (~r8_reg[i] + CW'(1)) : r8_reg[i];
            end
        end

        // Stage 5: sum of absolute fractions against three quarters
        total5 = (FW+2)'(m4_reg[0]) + (FW+2)'(m4_reg[1]) + (FW+2)'(m4_reg[2]);
        flip5_next = total5 > WRAP_TH;
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        byp_reg   <= byp_next;
        dly_reg   <= dly_next;
        mag1_reg  <= mag1_next;
        n1_reg    <= n1_next;
        phi2_reg  <= phi2_next;
        plo2_reg  <= plo2_next;
        n2_reg    <= n2_next;
        m3_reg    <= m3_next;
        n3_reg    <= n3_next;
        m4_reg    <= m4_next;
        n4_reg    <= n4_next;
        m5_reg    <= m5_next;
        n5_reg    <= n5_next;
        flip5_reg <= flip5_next;
        m6_reg    <= m6_next;
        n6_reg    <= n6_next;
        p7_reg    <= p7_next;
        n7_reg    <= n7_next;
        r8_reg    <= r8_next;
        n8_reg    <= n8_next;
        img_reg   <= img_next;
    end

    assign done    = vld_reg[LAT];
    assign image_x = img_reg[0];
    assign image_y = img_reg[1];
    assign image_z = img_reg[2];

`ifndef ASSERT_OFF
    // Every accepted vector comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted vector did not produce a result");

    // A folded fraction never exceeds one half
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> ((m5_reg[0] <= FHALF) && (m5_reg[1] <= FHALF)
                        && (m5_reg[2] <= FHALF)))
        else $error("folded fraction above one half");

    // A zero fraction on the x lane carries a positive sign
    a_zero_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[5] && (m5_reg[0] == '0)) |-> !n5_reg[0])
        else $error("zero fraction marked negative");

    // Truncated magnitude entering the scale-back stays within one half
    a_m32_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] |-> ((m6_reg[0] <= (IW'(1) << (IW - 1)))
                        && (m6_reg[1] <= (IW'(1) << (IW - 1)))
                        && (m6_reg[2] <= (IW'(1) << (IW - 1)))))
        else $error("scale-back magnitude out of range");
`endif

endmodule

/* tb/tb.sv */
module tb;

    localparam int CW = tomi_pkg::COORD_WIDTH_DEF;
    localparam int FB = tomi_pkg::FRAC_BITS_DEF;
    localparam int FW = FB + 32;
    localparam int IDXW = tomi_pkg::CFG_IDX_W;
    localparam int DATW = tomi_pkg::CFG_DATA_W;
    localparam int PERW = tomi_pkg::PERIOD_W;
    localparam int INVW = tomi_pkg::INV_W;
    localparam logic [FW-1:0] HALF_TURN = {1'b1, {(FW-1){1'b0}}};
    localparam logic [FW+1:0] FOLD_LIMIT = (FW+2)'(3) << (FW - 2);
    localparam logic [IDXW-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam logic [PERW-1:0] PERIOD_ONE = 31'h0001_0000;
    localparam logic [PERW-1:0] PERIOD_MAX = 31'h7FFF_FFFF;
    localparam logic [INVW-1:0] INV_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } image_vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] disp_x = '0;
    logic signed [CW-1:0] disp_y = '0;
    logic signed [CW-1:0] disp_z = '0;
    logic done;
    logic signed [CW-1:0] image_x;
    logic signed [CW-1:0] image_y;
    logic signed [CW-1:0] image_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDXW-1:0] cfg_index = '0;
    logic [DATW-1:0] cfg_data = '0;

    // Shadow copy of the register file
    logic [PERW-1:0] period_reg [3] = '{tomi_pkg::PERIOD_RST, tomi_pkg::PERIOD_RST,
                                        tomi_pkg::PERIOD_RST};
    logic [INVW-1:0] inv_reg [3] = '{tomi_pkg::INV_RST, tomi_pkg::INV_RST,
                                     tomi_pkg::INV_RST};
    logic solvent_reg = tomi_pkg::SOLVENT_RST;

    image_vec_t image_queue [$];
    int mismatch_count = 0;
    int sender_idle_pct = 0;

    truncated_octahedron_min_image u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .disp_x    (disp_x),
        .disp_y    (disp_y),
        .disp_z    (disp_z),
        .done      (done),
        .image_x   (image_x),
        .image_y   (image_y),
        .image_z   (image_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Fraction of one component as sign and magnitude, wrapped into [-0.5,0.5]
    function automatic logic [FW-1:0] wrap_fraction(input logic [CW-1:0] d,
                                                     input logic [INVW-1:0] inv,
                                                     output logic neg);
        logic [CW-1:0] mag;
        logic [63:0] prod;
        logic [FW-1:0] m;
        neg = d[CW-1];
        mag = neg ? -d : d;
        prod = 64'(mag) * 64'(inv);
        m = prod[FW-1:0];
        if (m == '0)
            neg = 1'b0;
        // exactly one half keeps its magnitude and flips its sign
        if (m[FW-1])
        begin
            m = -m;
            neg = !neg;
        end
        return m;
    endfunction

    // Scale a fraction back by its period, round half away, saturate, apply sign
    function automatic logic [CW-1:0] rescale(input logic [FW-1:0] m, input logic neg,
                                              input logic [PERW-1:0] period);
        logic [63:0] prod;
        logic [63:0] r;
        logic [63:0] lim;
        prod = 64'(m[FW-1:FB]) * 64'(period);
        r = (prod + 64'h8000_0000) >> 32;
        lim = 64'd1 << (CW - 1);
        if (neg)
        begin
            if (r > lim)
                r = lim;
            return -r[CW-1:0];
        end
        if (r > lim - 1)
            r = lim - 1;
        return r[CW-1:0];
    endfunction

    function automatic image_vec_t predict_image(input logic [CW-1:0] dx,
                                                 input logic [CW-1:0] dy,
                                                 input logic [CW-1:0] dz);
        image_vec_t res;
        logic [FW-1:0] m [3];
        logic neg [3];
        logic [CW-1:0] d [3];
        logic [CW-1:0] img [3];
        logic [FW+1:0] sum;
        d = '{dx, dy, dz};
        if (!solvent_reg)
        begin
            res.x = dx;
            res.y = dy;
            res.z = dz;
            return res;
        end
        for (int a = 0; a < 3; a++)
            m[a] = wrap_fraction(d[a], inv_reg[a], neg[a]);
        sum = (FW+2)'(m[0]) + (FW+2)'(m[1]) + (FW+2)'(m[2]);
        // fold across the hexagonal faces: take half toward each sign
        if (sum > FOLD_LIMIT)
        begin
            for (int a = 0; a < 3; a++)
            begin
                m[a] = HALF_TURN - m[a];
                neg[a] = (m[a] == '0) ? 1'b0 : !neg[a];
            end
        end
        for (int a = 0; a < 3; a++)
            img[a] = rescale(m[a], neg[a], period_reg[a]);
        res.x = img[0];
        res.y = img[1];
        res.z = img[2];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        if (mismatch_count < 40)
            $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Compare every result transaction with the oldest pending image
    always @(posedge clk)
    begin : check_results
        image_vec_t want;
        if (rst_n && done)
        begin
            if (image_queue.size() == 0)
            begin
                report_mismatch("unrequested image_x", image_x, '0);
            end
            else
            begin
                want = image_queue.pop_front();
                if (image_x !== want.x)
                    report_mismatch("image_x", image_x, want.x);
                if (image_y !== want.y)
                    report_mismatch("image_y", image_y, want.y);
                if (image_z !== want.z)
                    report_mismatch("image_z", image_z, want.z);
            end
        end
    end

    // Send one displacement transaction, idling first at the current rate
    task automatic send_vector(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input logic [CW-1:0] z);
        image_vec_t want;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        want = predict_image(x, y, z);
        start <= 1'b1;
        disp_x <= x;
        disp_y <= y;
        disp_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        image_queue.push_back(want);
    endtask

    // Hold off the sender until every pending image has come back
    task automatic drain_images();
        start <= 1'b0;
        @(posedge clk);
        while (image_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDXW-1:0] idx,
                             input logic [DATW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tomi_pkg::CFG_PERIOD_X:     period_reg[0] = data[PERW-1:0];
            tomi_pkg::CFG_PERIOD_Y:     period_reg[1] = data[PERW-1:0];
            tomi_pkg::CFG_PERIOD_Z:     period_reg[2] = data[PERW-1:0];
            tomi_pkg::CFG_INV_PERIOD_X: inv_reg[0] = data[INVW-1:0];
            tomi_pkg::CFG_INV_PERIOD_Y: inv_reg[1] = data[INVW-1:0];
            tomi_pkg::CFG_INV_PERIOD_Z: inv_reg[2] = data[INVW-1:0];
            tomi_pkg::CFG_SOLVENT:      solvent_reg = data[0];
            default:                    ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_axes(input logic [DATW-1:0] period,
                            input logic [DATW-1:0] inv);
        write_reg(tomi_pkg::CFG_PERIOD_X, period);
        write_reg(tomi_pkg::CFG_PERIOD_Y, period);
        write_reg(tomi_pkg::CFG_PERIOD_Z, period);
        write_reg(tomi_pkg::CFG_INV_PERIOD_X, inv);
        write_reg(tomi_pkg::CFG_INV_PERIOD_Y, inv);
        write_reg(tomi_pkg::CFG_INV_PERIOD_Z, inv);
    endtask

    // Pick a fresh register setting: mostly matched period pairs, some random pairs, some corners
    task automatic randomize_registers();
        logic [31:0] per;
        logic [63:0] inv;
        int mode;
        int sh;
        mode = $urandom_range(9);
        for (int a = 0; a < 3; a++)
        begin
            if (mode == 0)
            begin
                per = $urandom_range(1) ? PERIOD_MAX : PERIOD_ONE;
                inv = $urandom_range(1) ? INV_MAX : 1;
            end
            else if (mode == 1)
            begin
                per = $urandom;
                inv = $urandom;
            end
            else
            begin
                sh = $urandom_range(14);
                per = 32'h1_0000 + ($urandom & ((32'h1_0000 << sh) - 1));
                inv = (64'd1 << FW) / per;
                if (inv > INV_MAX)
                    inv = INV_MAX;
            end
            write_reg(tomi_pkg::cfg_reg_t'(tomi_pkg::CFG_PERIOD_X + a), per);
            write_reg(tomi_pkg::cfg_reg_t'(tomi_pkg::CFG_INV_PERIOD_X + a), inv[31:0]);
        end
        write_reg(tomi_pkg::CFG_SOLVENT, ($urandom_range(7) != 0) ? 32'd1 : 32'd0);
    endtask

    // Random coordinate: raw bits, near a half-period multiple, or within a period
    function automatic logic [CW-1:0] random_coord(input logic [PERW-1:0] period);
        longint base;
        int k;
        case ($urandom_range(2))
            0:
            begin
                return $urandom;
            end
            1:
            begin
                k = int'($urandom_range(16)) - 8;
                base = longint'(k) * longint'(period) / 2;
                return CW'(base + longint'($urandom_range(6)) - 3);
            end
            default:
            begin
                base = longint'($urandom_range(period));
                return CW'($urandom_range(1) ? -base : base);
            end
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_vector('0, '0, '0);
        send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_vector(32'h0000_8000, -32'sh8000, 32'h0001_8000);
    endtask

    // Period 2.0 makes the one-half and three-quarter tests exact
    task automatic test_half_boundary();
        drain_images();
        set_axes(32'h0002_0000, 32'h8000_0000);
        send_vector(32'h0001_0000, -32'sh1_0000, '0);
        send_vector(32'h0000_FFFF, 32'h0001_0001, -32'sh1_0001);
        send_vector(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_vector(32'h0000_8001, 32'h0000_8000, -32'sh8000);
        send_vector(32'h0003_0000, -32'sh3_0000, 32'h0005_0000);
    endtask

    task automatic test_octahedral_fold();
        drain_images();
        set_axes(PERIOD_ONE, INV_MAX);
        send_vector(32'h0000_6666, 32'h0000_6666, 32'h0000_6666);
        send_vector(-32'sh4CCC, 32'h0000_4CCC, -32'sh4CCC);
        send_vector('0, 32'h0000_7333, 32'h0000_7333);
        send_vector(32'h0000_4000, 32'h0000_4000, 32'h0000_4000);
    endtask

    task automatic test_bypass();
        drain_images();
        write_reg(tomi_pkg::CFG_SOLVENT, 32'd0);
        send_vector(32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_vector(32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678);
        drain_images();
        write_reg(tomi_pkg::CFG_SOLVENT, 32'd1);
    endtask

    // Largest and degenerate registers, masking of wide data, unused index
    task automatic test_register_corners();
        drain_images();
        set_axes(PERIOD_MAX, INV_MAX);
        send_vector(32'h4000_0001, 32'hBFFF_FFFF, 32'h7FFF_0000);
        drain_images();
        write_reg(tomi_pkg::CFG_INV_PERIOD_X, '0);
        write_reg(tomi_pkg::CFG_PERIOD_Y, '0);
        write_reg(tomi_pkg::CFG_PERIOD_Z, 32'hFFFF_FFFF);
        write_reg(tomi_pkg::CFG_INV_PERIOD_Z, 32'd1);
        send_vector(32'h1234_5678, 32'h8765_4321, 32'h8000_0000);
        drain_images();
        set_axes($urandom, $urandom);
        send_vector($urandom, $urandom, $urandom);
        drain_images();
        write_reg(tomi_pkg::CFG_SOLVENT, 32'd2);
        send_vector(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        drain_images();
        write_reg(tomi_pkg::CFG_SOLVENT, 32'd3);
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        send_vector(32'h0001_8000, -32'sh2_8000, 32'h0000_C000);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int count);
        int per_block;
        sender_idle_pct = idle_pct;
        per_block = count / 10;
        for (int b = 0; b < 10; b++)
        begin
            drain_images();
            randomize_registers();
            for (int i = 0; i < per_block; i++)
                send_vector(random_coord(period_reg[0]), random_coord(period_reg[1]),
                            random_coord(period_reg[2]));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle_pct = 20;
        test_reset_defaults();
        test_half_boundary();
        test_octahedral_fold();
        test_bypass();
        test_register_corners();
        test_random_traffic(38, 610);
        test_random_traffic(78, 610);
        test_random_traffic(0, 610);
        drain_images();
        repeat (20) @(posedge clk);
        if (image_queue.size() != 0)
            report_mismatch("images left pending", '0, '0);
        if (mismatch_count == 0)
            $display("** truncated_octahedron_min_image: PASSED **");
        else
            $display("** truncated_octahedron_min_image: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4_000_000;
        $display("** truncated_octahedron_min_image: FAILED **");
        $finish;
    end

endmodule
